// ===== sv/max_pool_2d_stream_unit_macros.svh =====
// ----------------------------------------------------------------------------
// max_pool_2d_stream_unit_macros.svh
// Assertion macros used by the max pooling stream checker.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_STREAM_UNIT_MACROS_SVH
`define MAX_POOL_2D_STREAM_UNIT_MACROS_SVH

// Concurrent assertion sampled on aclk, ignored while reset is held
`define MP2D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent assertion sampled on aclk that also holds during reset
`define MP2D_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/mp2d_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2d_pkg
// Sizes, register codes and shared types of the max pooling stream unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

    // Block limits
    localparam int MAX_MAP     = 256;
    localparam int MAX_WINDOW  = 8;
    localparam int VALUE_BITS  = 16;
    localparam int MAX_STEP    = 8;
    localparam int MAX_PLANES  = 1024;
    localparam int STORE_DEPTH = MAX_WINDOW * MAX_MAP;

    // Derived widths
    localparam int POS_W    = $clog2(MAX_MAP);
    localparam int MAP_W    = POS_W + 1;
    localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W    = $clog2(MAX_WINDOW) + 1;
    localparam int PH_W     = $clog2(MAX_STEP);
    localparam int STEP_W   = PH_W + 1;
    localparam int PPOS_W   = $clog2(MAX_PLANES);
    localparam int PLANES_W = PPOS_W + 1;
    localparam int ADDR_W   = SLOT_W + POS_W;

    // Configuration register fields
    localparam int MAP_CFG_W    = 9;
    localparam int WIN_CFG_W    = 4;
    localparam int STEP_CFG_W   = 4;
    localparam int PLANES_CFG_W = 11;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_SIZE    = 2'd0,
        REG_WINDOW_SIZE = 2'd1,
        REG_STEP_SIZE   = 2'd2,
        REG_PLANE_COUNT = 2'd3
    } cfg_reg_t;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Position tracker to sequencer: what the current sample does
    typedef struct packed {
        logic              fire;
        logic [ADDR_W-1:0] wr_addr;
        logic [POS_W-1:0]  col_base;
        logic [WIN_W-1:0]  win;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic              plane_done;
        logic              sample_done;
    } pos_info_t;

endpackage

`default_nettype wire

// ===== sv/max_pool_2d_stream_unit.sv =====
// ----------------------------------------------------------------------------
// max_pool_2d_stream_unit
// Streaming 2-D max pooling over square Q8.8 planes with a line store.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one Q8.8 sample per transaction, raster order, one
//   channel plane after another. m_ channel carries one pooled result per
//   completed window: tdata holds value, output row and output column,
//   tlast marks the last window of a plane, tuser the last of the sample.
//   A sample that closes no window leaves s_tready high. A sample that
//   closes a window is written to the line store, then ST_READ issues
//   window_size^2 reads through the single read port of the line store,
//   each folded by one compare unit; ST_DRAIN folds the last read and
//   ST_EMIT loads the output register, which drives the result on m_.
//   The output register lets the next sample be taken while a result
//   waits; a stalled receiver holds back the block only when the next
//   result is ready to load.
//   Reset (synchronous, aresetn low) restores the default registers and
//   returns to row 0, column 0, plane 0; the line store is not cleared and
//   needs no clearing pass. A register write restarts the stream position.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_stream_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // Sample input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mp2d_pkg::S_TDATA_W-1:0]  s_tdata,  // [15:0] sample_value
    // Pooled result
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [mp2d_pkg::M_TDATA_W-1:0]  m_tdata,  // [15:0] pooled_value,
                                                           // [23:16] out_row,
                                                           // [31:24] out_col
    output logic                                 m_tlast,  // plane_done
    output logic                                 m_tuser   // [0] sample_done
);

    import mp2d_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    pos_info_t info;
    logic      s_fire;

    logic [POS_W-1:0]  col_base_reg, col_base_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [POS_W-1:0]  out_row_reg, out_row_next;
    logic [POS_W-1:0]  out_col_reg, out_col_next;
    logic              pdone_reg, pdone_next;
    logic              sdone_reg, sdone_next;
    logic [SLOT_W-1:0] a_cnt_reg, a_cnt_next;
    logic [SLOT_W-1:0] b_cnt_reg, b_cnt_next;
    logic              rd_valid_reg;

    logic [SLOT_W-1:0]     cnt_last;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [VALUE_BITS-1:0] rd_data;
    logic [VALUE_BITS-1:0] max_value;
    logic                  win_start;
    logic                  out_load;

    logic                  m_tvalid_reg;
    logic [VALUE_BITS-1:0] m_value_reg;
    logic [POS_W-1:0]      m_row_reg;
    logic [POS_W-1:0]      m_col_reg;
    logic                  m_last_reg;
    logic                  m_user_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Position tracking and configuration
    mp2d_pos_track u_pos_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .step         (s_fire),
        .info         (info)
    );

    // Line store: row r lives at slot r mod window
    mp2d_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (info.wr_addr),
        .wr_data (s_tdata[VALUE_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Running maximum over the window words
    mp2d_max_unit u_max_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (win_start),
        .en      (rd_valid_reg),
        .data_in (rd_data),
        .max_out (max_value)
    );

    assign win_start = s_fire && info.fire;
    assign cnt_last  = SLOT_W'(win_reg - WIN_W'(1));
    assign rd_en     = (state_reg == ST_READ);
    // Visit every slot; window columns run from col_base upward
    assign rd_addr   = {a_cnt_reg, col_base_reg + POS_W'(b_cnt_reg)};
    assign out_load  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // Sequence window reads
    always_comb begin
        state_next    = state_reg;
        col_base_next = col_base_reg;
        win_next      = win_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        pdone_next    = pdone_reg;
        sdone_next    = sdone_reg;
        a_cnt_next    = a_cnt_reg;
        b_cnt_next    = b_cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (win_start) begin
                    state_next    = ST_READ;
                    col_base_next = info.col_base;
                    win_next      = info.win;
                    out_row_next  = info.out_row;
                    out_col_next  = info.out_col;
                    pdone_next    = info.plane_done;
                    sdone_next    = info.sample_done;
                    a_cnt_next    = '0;
                    b_cnt_next    = '0;
                end
            end
            ST_READ: begin
                if (b_cnt_reg == cnt_last) begin
                    b_cnt_next = '0;
                    a_cnt_next = a_cnt_reg + SLOT_W'(1);
                    if (a_cnt_reg == cnt_last) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    b_cnt_next = b_cnt_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;
        end
    end

    // Window context registers
    always_ff @(posedge aclk) begin
        col_base_reg <= col_base_next;
        win_reg      <= win_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        pdone_reg    <= pdone_next;
        sdone_reg    <= sdone_next;
        a_cnt_reg    <= a_cnt_next;
        b_cnt_reg    <= b_cnt_next;
    end

    // Output register: load a finished window, drop the flag once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_value_reg <= max_value;
            m_row_reg   <= out_row_reg;
            m_col_reg   <= out_col_reg;
            m_last_reg  <= pdone_reg;
            m_user_reg  <= sdone_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_col_reg, m_row_reg, m_value_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== sv/mp2d_ram.sv =====
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/mp2d_pos_track.sv =====
// ----------------------------------------------------------------------------
// mp2d_pos_track
// Configuration registers and raster position tracking; flags window ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_pos_track (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            step,
    output mp2d_pkg::pos_info_t                  info
);

    import mp2d_pkg::*;

    logic [MAP_CFG_W-1:0]    map_size_reg;
    logic [WIN_CFG_W-1:0]    window_size_reg;
    logic [STEP_CFG_W-1:0]   step_size_reg;
    logic [PLANES_CFG_W-1:0] plane_count_reg;

    logic [POS_W-1:0]  row_pos_reg, row_pos_next;
    logic [POS_W-1:0]  col_pos_reg, col_pos_next;
    logic [SLOT_W-1:0] row_slot_reg, row_slot_next;
    logic [PH_W-1:0]   row_ph_reg, row_ph_next;
    logic [PH_W-1:0]   col_ph_reg, col_ph_next;
    logic [POS_W-1:0]  out_row_reg, out_row_next;
    logic [POS_W-1:0]  out_col_reg, out_col_next;
    logic [PPOS_W-1:0] plane_pos_reg, plane_pos_next;

    logic [MAP_W-1:0]    map_eff;
    logic [WIN_W-1:0]    win_eff;
    logic [STEP_W-1:0]   step_eff;
    logic [PLANES_W-1:0] planes_eff;
    logic [MAP_W-1:0]    win_ext;
    logic [MAP_W-1:0]    row_p1, col_p1;
    logic                row_fit, col_fit, row_last, col_last;
    logic                row_ph_wrap, col_ph_wrap, slot_wrap;
    logic [PLANES_W-1:0] plane_p1;
    logic                plane_done;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_size_reg    <= MAP_CFG_W'(28);
            window_size_reg <= WIN_CFG_W'(2);
            step_size_reg   <= STEP_CFG_W'(2);
            plane_count_reg <= PLANES_CFG_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_MAP_SIZE:    map_size_reg    <= cfg_wr_data[MAP_CFG_W-1:0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_wr_data[WIN_CFG_W-1:0];
                REG_STEP_SIZE:   step_size_reg   <= cfg_wr_data[STEP_CFG_W-1:0];
                REG_PLANE_COUNT: plane_count_reg <= cfg_wr_data[PLANES_CFG_W-1:0];
                default:         map_size_reg    <= map_size_reg;
            endcase
        end
    end

    // Clamp register values into their working ranges
    always_comb begin
        if (map_size_reg == '0) begin
            map_eff = MAP_W'(1);
        end else if (MAP_W'(map_size_reg) > MAP_W'(MAX_MAP)) begin
            map_eff = MAP_W'(MAX_MAP);
        end else begin
            map_eff = MAP_W'(map_size_reg);
        end

        if (window_size_reg == '0) begin
            win_eff = WIN_W'(1);
        end else if (WIN_W'(window_size_reg) > WIN_W'(MAX_WINDOW)) begin
            win_eff = WIN_W'(MAX_WINDOW);
        end else begin
            win_eff = WIN_W'(window_size_reg);
        end

        if (step_size_reg == '0) begin
            step_eff = STEP_W'(1);
        end else if (STEP_W'(step_size_reg) > STEP_W'(MAX_STEP)) begin
            step_eff = STEP_W'(MAX_STEP);
        end else begin
            step_eff = STEP_W'(step_size_reg);
        end

        if (plane_count_reg == '0) begin
            planes_eff = PLANES_W'(1);
        end else if (PLANES_W'(plane_count_reg) > PLANES_W'(MAX_PLANES)) begin
            planes_eff = PLANES_W'(MAX_PLANES);
        end else begin
            planes_eff = PLANES_W'(plane_count_reg);
        end
    end

    // Decide whether the current sample closes a window
    always_comb begin
        win_ext     = MAP_W'(win_eff);
        row_p1      = MAP_W'(row_pos_reg) + MAP_W'(1);
        col_p1      = MAP_W'(col_pos_reg) + MAP_W'(1);
        row_fit     = (row_p1 >= win_ext);
        col_fit     = (col_p1 >= win_ext);
        row_last    = (row_p1 >= map_eff);
        col_last    = (col_p1 >= map_eff);
        row_ph_wrap = ((STEP_W'(row_ph_reg) + STEP_W'(1)) == step_eff);
        col_ph_wrap = ((STEP_W'(col_ph_reg) + STEP_W'(1)) == step_eff);
        slot_wrap   = ((WIN_W'(row_slot_reg) + WIN_W'(1)) == win_eff);
        plane_p1    = PLANES_W'(plane_pos_reg) + PLANES_W'(1);
        // last window of a plane: the next window start would not fit
        plane_done  = ((MAP_W'(row_pos_reg) + MAP_W'(step_eff)) >= map_eff) &&
                      ((MAP_W'(col_pos_reg) + MAP_W'(step_eff)) >= map_eff);

        info.fire        = (win_ext <= map_eff) && row_fit && col_fit &&
                           (row_ph_reg == '0) && (col_ph_reg == '0);
        info.wr_addr     = {row_slot_reg, col_pos_reg};
        info.col_base    = col_pos_reg - POS_W'(win_eff - WIN_W'(1));
        info.win         = win_eff;
        info.out_row     = out_row_reg;
        info.out_col     = out_col_reg;
        info.plane_done  = plane_done;
        info.sample_done = plane_done && (plane_p1 == planes_eff);
    end

    // Advance the raster position
    always_comb begin
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg + POS_W'(1);
        row_slot_next  = row_slot_reg;
        row_ph_next    = row_ph_reg;
        col_ph_next    = '0;
        out_row_next   = out_row_reg;
        out_col_next   = '0;
        plane_pos_next = plane_pos_reg;

        if (col_fit) begin
            col_ph_next  = col_ph_wrap ? '0 : col_ph_reg + PH_W'(1);
            out_col_next = col_ph_wrap ? out_col_reg + POS_W'(1) : out_col_reg;
        end

        if (col_last) begin
            col_pos_next = '0;
            col_ph_next  = '0;
            out_col_next = '0;
            if (row_last) begin
                row_pos_next   = '0;
                row_slot_next  = '0;
                row_ph_next    = '0;
                out_row_next   = '0;
                plane_pos_next = (plane_p1 >= planes_eff) ? '0 : plane_p1[PPOS_W-1:0];
            end else begin
                row_pos_next  = row_pos_reg + POS_W'(1);
                row_slot_next = slot_wrap ? '0 : row_slot_reg + SLOT_W'(1);
                if (row_fit) begin
                    row_ph_next  = row_ph_wrap ? '0 : row_ph_reg + PH_W'(1);
                    out_row_next = row_ph_wrap ? out_row_reg + POS_W'(1) : out_row_reg;
                end else begin
                    row_ph_next  = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    // Restart on any register write, advance on each accepted sample
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            row_slot_reg  <= '0;
            row_ph_reg    <= '0;
            col_ph_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            plane_pos_reg <= '0;
        end else if (step) begin
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            row_slot_reg  <= row_slot_next;
            row_ph_reg    <= row_ph_next;
            col_ph_reg    <= col_ph_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            plane_pos_reg <= plane_pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mp2d_max_unit.sv =====
// ----------------------------------------------------------------------------
// mp2d_max_unit
// Shared signed compare unit that folds line-store words into a running max.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_max_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            clear,
    input  wire logic                            en,
    input  wire logic [mp2d_pkg::VALUE_BITS-1:0] data_in,
    output logic      [mp2d_pkg::VALUE_BITS-1:0] max_out
);

    import mp2d_pkg::*;

    logic                  have_reg;
    logic [VALUE_BITS-1:0] max_reg;
    logic                  take;

    // Take the first word, then any word that is strictly larger
    assign take = !have_reg || ($signed(data_in) > $signed(max_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            have_reg <= 1'b0;
        end else if (en) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !clear && take) begin
            max_reg <= data_in;
        end
    end

    assign max_out = max_reg;

endmodule

`default_nettype wire

// ===== sv/mp2d_checker.sv =====
// ----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks of the max pooling stream unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_pool_2d_stream_unit_macros.svh"

module mp2d_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [mp2d_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                            m_tlast,
    input wire logic                            m_tuser
);

    import mp2d_pkg::*;

    logic                 m_stall;
    logic [M_TDATA_W+1:0] m_word;

    // Result transaction waiting on the receiver, and everything it carries
    assign m_stall = m_tvalid && !m_tready;
    assign m_word  = {m_tdata, m_tlast, m_tuser};

    // Reset empties the output register
    `MP2D_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result transaction holds
    `MP2D_ASSERT(a_out_hold, m_stall |=> m_tvalid && $stable(m_word), "stalled result changed")

    // End of sample only on the last window of a plane
    `MP2D_ASSERT(a_sample_in_plane, m_tvalid && m_tuser |-> m_tlast, "sample_done alone")

    // A new result is loaded only while the input side is busy
    `MP2D_ASSERT(a_load_while_busy, $rose(m_tvalid) |-> !$past(s_tready), "load while ready")

endmodule

bind max_pool_2d_stream_unit mp2d_checker u_mp2d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
